// ===== design/psaw_pkg.sv =====
// ----------------------------------------------------------------------------
// psaw_pkg: shared types and constants for the PolyBLEP sawtooth oscillator
// Default sizes, input kind codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package psaw_pkg;

  localparam int unsigned PHASE_BITS_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CFG_BITS        = 32;
  localparam int unsigned NEW_PHASE_BITS  = 32;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef struct packed {
    logic load_phase;
    logic advance;
    logic div_init;
    logic div_step;
    logic square;
    logic sum_load;
  } psaw_cmd_t;

  typedef struct packed {
    logic div_last;
  } psaw_status_t;

endpackage

`default_nettype wire

// ===== design/psaw_in_if.sv =====
// ----------------------------------------------------------------------------
// psaw_in_if: input channel of the oscillator
// Valid/ready channel carrying the item kind and a phase value to load.
// ----------------------------------------------------------------------------
`default_nettype none

interface psaw_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [psaw_pkg::NEW_PHASE_BITS-1:0] new_phase;

  modport source (output valid, output kind, output new_phase, input ready);
  modport sink   (input valid, input kind, input new_phase, output ready);
endinterface

`default_nettype wire

// ===== design/psaw_out_if.sv =====
// ----------------------------------------------------------------------------
// psaw_out_if: output channel of the oscillator
// Valid/ready channel carrying one signed sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface psaw_out_if #(
  parameter int unsigned SAMPLE_BITS = psaw_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/psaw_datapath.sv =====
// ----------------------------------------------------------------------------
// psaw_datapath: phase accumulator, ratio divider and correction arithmetic
// Holds phase and step, runs a restoring divider one bit per cycle, squares
// the ratio, then sums, rounds and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psaw_datapath #(
  parameter int unsigned PHASE_BITS  = psaw_pkg::PHASE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = psaw_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [psaw_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  input  wire  [psaw_pkg::NEW_PHASE_BITS-1:0]    new_phase_i,
  input  wire  psaw_pkg::psaw_cmd_t              cmd_i,
  output psaw_pkg::psaw_status_t                 status_o,
  output logic signed [SAMPLE_BITS-1:0]          sample_o
);
  import psaw_pkg::*;

  localparam int unsigned P     = PHASE_BITS;
  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned FRAC  = 2 * S;
  localparam int unsigned TW    = FRAC + 3;
  localparam int unsigned RW    = TW - S - 1;
  localparam int unsigned CW    = $clog2(S);
  localparam int unsigned EXT_W = (P > FRAC + 1) ? P : FRAC + 1;
  localparam int unsigned SH_L  = (FRAC + 1 >= P) ? FRAC + 1 - P : 0;
  localparam int unsigned SH_R  = (FRAC + 1 >= P) ? 0 : P - FRAC - 1;

  localparam logic [P:0]         PH_ONE = {1'b1, {P{1'b0}}};
  localparam logic [S:0]         Q_ONE  = {1'b1, {S{1'b0}}};
  localparam logic [TW-1:0]      F_ONE  = {3'b001, {FRAC{1'b0}}};
  localparam logic [TW-1:0]      RND    = {{(TW-S-1){1'b0}}, 1'b1, {S{1'b0}}};
  localparam logic signed [RW-1:0] RMAX = {3'b000, {(S-1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = {3'b111, {(S-1){1'b0}}};

  logic [P-1:0]        phase_q, phase_d;
  logic [P-1:0]        step_q, step_d;
  logic [P-1:0]        rem_q, rem_d;
  logic [S-1:0]        quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                after_q, after_d;
  logic                before_q, before_d;
  logic [2*S+1:0]      sq_q, sq_d;
  logic signed [S-1:0] sample_q, sample_d;

  logic [P:0]          sum_pd;
  logic [P:0]          one_minus_d;
  logic                after_w, before_w;
  logic [P:0]          r2;
  logic [P:0]          diff;
  logic                ge;
  logic [S:0]          w;
  logic [EXT_W-1:0]    ext_p;
  logic [EXT_W-1:0]    scaled_full;
  logic [FRAC:0]       scaled;
  logic signed [TW-1:0] naive;
  logic signed [TW-1:0] sq_s;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] rnd;
  logic signed [RW-1:0] res;

  always_comb begin
    sum_pd      = {1'b0, phase_q} + {1'b0, step_q};
    one_minus_d = PH_ONE - {1'b0, step_q};
    after_w     = (|step_q) && (phase_q < step_q);
    before_w    = (|step_q) && !after_w && ({1'b0, phase_q} > one_minus_d);

    r2   = {rem_q, 1'b0};
    ge   = (r2 >= {1'b0, step_q});
    diff = r2 - {1'b0, step_q};

    w = after_q ? (Q_ONE - {1'b0, quo_q}) : {1'b0, quo_q};

    ext_p       = EXT_W'(phase_q);
    scaled_full = (ext_p << SH_L) >> SH_R;
    scaled      = scaled_full[FRAC:0];
    naive       = $signed(F_ONE) - $signed(TW'(scaled));
    sq_s        = $signed(TW'(sq_q));
    if (after_q) begin
      total = naive - sq_s;
    end else if (before_q) begin
      total = naive + sq_s;
    end else begin
      total = naive;
    end
    rnd = total + $signed(RND);
    res = rnd[TW-1:S+1];
    if (res > RMAX) begin
      sample_d = RMAX[S-1:0];
    end else if (res < RMIN) begin
      sample_d = RMIN[S-1:0];
    end else begin
      sample_d = res[S-1:0];
    end

    phase_d  = phase_q;
    step_d   = step_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    after_d  = after_q;
    before_d = before_q;
    sq_d     = sq_q;

    if (cfg_we_i) begin
      step_d = P'(cfg_wdata_i);
    end
    if (cmd_i.load_phase) begin
      phase_d = P'(new_phase_i);
    end
    if (cmd_i.advance) begin
      phase_d = sum_pd[P-1:0];
    end
    if (cmd_i.div_init) begin
      after_d  = after_w;
      before_d = before_w;
      rem_d    = after_w ? phase_q : (before_w ? sum_pd[P-1:0] : '0);
      quo_d    = '0;
      cnt_d    = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? diff[P-1:0] : r2[P-1:0];
      quo_d = {quo_q[S-2:0], ge};
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.square) begin
      sq_d = (2*S+2)'(w) * (2*S+2)'(w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      step_q   <= '0;
      cnt_q    <= '0;
      after_q  <= 1'b0;
      before_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      after_q  <= after_d;
      before_q <= before_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    sq_q  <= sq_d;
    if (cmd_i.sum_load) begin
      sample_q <= sample_d;
    end
  end

  assign status_o.div_last = (cnt_q == CW'(S - 1));
  assign sample_o          = sample_q;

endmodule

`default_nettype wire

// ===== design/psaw_ctrl.sv =====
// ----------------------------------------------------------------------------
// psaw_ctrl: sequencing controller for the oscillator
// Steps one tick through classify, divide, square and round, and owns the
// input ready and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module psaw_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  wire                     in_kind_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output psaw_pkg::psaw_cmd_t     cmd_o,
  input  wire psaw_pkg::psaw_status_t status_i
);
  import psaw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_DIVIDE,
    ST_SQUARE,
    ST_ROUND
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  always_comb begin
    accept   = in_valid_i && (state_q == ST_IDLE);
    out_free = !out_valid_q || out_ready_i;

    cmd_o            = '0;
    cmd_o.load_phase = accept && (in_kind_i == KIND_LOAD);
    cmd_o.advance    = accept && (in_kind_i == KIND_TICK);
    cmd_o.div_init   = (state_q == ST_CLASS);
    cmd_o.div_step   = (state_q == ST_DIVIDE);
    cmd_o.square     = (state_q == ST_SQUARE);
    cmd_o.sum_load   = (state_q == ST_ROUND) && out_free;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.advance) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_ROUND;
      ST_ROUND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.sum_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum_load |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending output");

  a_tick_classify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |=> cmd_o.div_init)
    else $error("tick not followed by classification");

  a_init_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_init |=> (cmd_o.div_step && !in_ready_o))
    else $error("divider not started after classification");

endmodule

`default_nettype wire

// ===== design/polyblep_saw_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// polyblep_saw_oscillator_top: band-limited falling sawtooth oscillator
// Phase accumulator with PolyBLEP correction around the wrap, Q1.15 output.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      kind, new_phase
//  out_o    out  valid/ready      sample
//  cfg      in   cfg_we_i         cfg_wdata_i (phase_step)
//
//  A tick runs through accept, classify, the bit-per-cycle restoring divider
//  for SAMPLE_BITS quotient bits, square and round/saturate.
//  A phase load is taken in the idle state and gives no output transaction.
//  Reset clears phase, step, controller state and output valid.
//  The input is taken again while a finished sample waits at the output;
//  the round stage holds only if the output register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module polyblep_saw_oscillator_top #(
  parameter int unsigned PHASE_BITS  = psaw_pkg::PHASE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = psaw_pkg::SAMPLE_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [psaw_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  psaw_in_if.sink                        in_i,
  psaw_out_if.source                     out_o
);
  import psaw_pkg::*;

  psaw_cmd_t    cmd;
  psaw_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic signed [SAMPLE_BITS-1:0] sample;

  psaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  psaw_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .new_phase_i (in_i.new_phase),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_o    (sample)
  );

  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid;
  assign out_o.sample = sample;

endmodule

`default_nettype wire
